// ===== design/cdq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and ring index helpers for the circular deque.
// ---------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef logic [2:0] req_type_t;
    typedef logic [1:0] status_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam req_type_t REQ_INS_FRONT = 3'd0;
    localparam req_type_t REQ_INS_REAR  = 3'd1;
    localparam req_type_t REQ_DEL_FRONT = 3'd2;
    localparam req_type_t REQ_DEL_REAR  = 3'd3;
    localparam req_type_t REQ_LIST      = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam idx_t IDX_LAST = IDX_W'(DEPTH - 1);

    function automatic idx_t ring_next(input idx_t i);
        idx_t r;
        if (i == IDX_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t ring_prev(input idx_t i);
        idx_t r;
        if (i == '0)
        begin
            r = IDX_LAST;
        end
        else
        begin
            r = i - idx_t'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/cdq_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_if
// Valid/ready channel interfaces for deque requests and their results.
// ---------------------------------------------------------------------------
interface cdq_req_if
    import cdq_pkg::*;
    ;
    logic      valid;
    logic      ready;
    req_type_t req_type;
    data_t     value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cdq_rsp_if
    import cdq_pkg::*;
    ;
    logic    valid;
    logic    ready;
    status_t status;
    data_t   data;
    logic    last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface
`default_nettype wire

// ===== design/cdq_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/circular_deque_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue kept in a ring held in a synchronous RAM.
//
//   channel   direction   carries
//   req       in          req_type, value
//   rsp       out         status, data, last
//
// Inserts, failed deletes and the empty list give their result in the cycle
// after acceptance. A successful delete passes the registered entry RAM read
// on into the result register. A list request reads the first element, then
// streams one per cycle unless the result register stalls. Requests are taken
// only while no earlier request is still producing results, and a stalled
// result register holds everything back. Reset leaves the deque empty.
// ---------------------------------------------------------------------------
module circular_deque_core
    import cdq_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    cdq_req_if.sink   req,
    cdq_rsp_if.source rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DATA = 1'b1;

    logic    state_reg, state_next;
    logic    list_reg, list_next;
    idx_t    idx_reg, idx_next;
    idx_t    front_reg, front_next;
    idx_t    rear_reg, rear_next;
    logic    empty_reg, empty_next;
    logic    valid_reg, valid_next;
    status_t status_reg, status_next;
    data_t   data_reg, data_next;
    logic    last_reg, last_next;

    logic  out_free;
    logic  accept;
    logic  full;
    logic  ram_we;
    idx_t  ram_waddr;
    logic  ram_re;
    idx_t  ram_raddr;
    data_t ram_rdata;

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = !empty_reg && (ring_next(rear_reg) == front_reg);

    always_comb
    begin
        state_next  = state_reg;
        list_next   = list_reg;
        idx_next    = idx_reg;
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        valid_next  = valid_reg && !rsp.ready;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_INS_FRONT, REQ_INS_REAR:
                        begin
                            valid_next = 1'b1;
                            data_next  = '0;
                            last_next  = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                ram_we      = 1'b1;
                                empty_next  = 1'b0;
                                if (empty_reg)
                                begin
                                    front_next = '0;
                                    rear_next  = '0;
                                    ram_waddr  = '0;
                                end
                                else if (req.req_type == REQ_INS_FRONT)
                                begin
                                    front_next = ring_prev(front_reg);
                                    ram_waddr  = ring_prev(front_reg);
                                end
                                else
                                begin
                                    rear_next = ring_next(rear_reg);
                                    ram_waddr = ring_next(rear_reg);
                                end
                            end
                        end
                        REQ_DEL_FRONT, REQ_DEL_REAR:
                        begin
                            if (empty_reg)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_EMPTY;
                                data_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                list_next  = 1'b0;
                                state_next = S_DATA;
                                ram_raddr  = (req.req_type == REQ_DEL_FRONT) ?
                                             front_reg : rear_reg;
                                if (front_reg == rear_reg)
                                begin
                                    empty_next = 1'b1;
                                    front_next = '0;
                                    rear_next  = '0;
                                end
                                else if (req.req_type == REQ_DEL_FRONT)
                                begin
                                    front_next = ring_next(front_reg);
                                end
                                else
                                begin
                                    rear_next = ring_prev(rear_reg);
                                end
                            end
                        end
                        REQ_LIST:
                        begin
                            if (empty_reg)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_EMPTY;
                                data_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                idx_next   = front_reg;
                                list_next  = 1'b1;
                                state_next = S_DATA;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    data_next   = ram_rdata;
                    last_next   = !list_reg || (idx_reg == rear_reg);
                    if (!list_reg || (idx_reg == rear_reg))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = ring_next(idx_reg);
                        ram_re    = 1'b1;
                        ram_raddr = ring_next(idx_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            list_reg  <= 1'b0;
            idx_reg   <= '0;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            list_reg  <= list_next;
            idx_reg   <= idx_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign rsp.valid  = valid_reg;
    assign rsp.status = status_reg;
    assign rsp.data   = data_reg;
    assign rsp.last   = last_reg;

endmodule
`default_nettype wire

// ===== verif/tb_circular_deque_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_circular_deque_core
// Drives deque requests over the request channel and predicts every result
// with a behavioural deque of its own, checking each result field by field
// in order. Directed requests cover the empty and full deque, wrapping and
// the unused request codes. Random traffic follows under changing idle
// patterns on both channels, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_circular_deque_core;
    import cdq_pkg::*;

    localparam req_type_t REQ_UNUSED_5 = 3'd5;
    localparam req_type_t REQ_UNUSED_6 = 3'd6;
    localparam req_type_t REQ_UNUSED_7 = 3'd7;

    localparam data_t VAL_MIN = 32'sh8000_0000;
    localparam data_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam data_t VAL_NEG_ONE = -32'sd1;
    localparam data_t VAL_ZERO = 32'sd0;

    localparam int CYCLE_LIMIT = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t status;
        data_t   data;
        logic    last;
    } deque_result_t;

    logic clk;
    logic rst_n;
    logic hold_rsp;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cycle_count;
    int   mismatch_count;

    data_t ring_copy [DEPTH];
    idx_t  head_pos;
    idx_t  tail_pos;
    bit    deque_void;

    deque_result_t pending_results[$];

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    circular_deque_core i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_circular_deque_core failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_rsp)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            check_result(rsp_ch.status, rsp_ch.data, rsp_ch.last);
        end
    end

    function automatic idx_t step_up(input idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? idx_t'(0) : idx_t'(i + 1);
    endfunction

    function automatic idx_t step_down(input idx_t i);
        return (i == idx_t'(0)) ? idx_t'(DEPTH - 1) : idx_t'(i - 1);
    endfunction

    function automatic void expect_result(input status_t st, input data_t d, input logic lst);
        deque_result_t r;
        r.status = st;
        r.data = d;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_deque();
        deque_void = 1'b1;
        head_pos = '0;
        tail_pos = '0;
    endfunction

    // Applies one accepted request to the deque copy and queues its results.
    function automatic void predict_request(input req_type_t kind, input data_t val);
        data_t taken;
        idx_t  pos;
        int    k;
        bit    at_end;
        case (kind)
            REQ_INS_FRONT, REQ_INS_REAR:
            begin
                if (!deque_void && step_up(tail_pos) == head_pos)
                begin
                    expect_result(ST_FULL, VAL_ZERO, 1'b1);
                end
                else
                begin
                    if (deque_void)
                    begin
                        deque_void = 1'b0;
                        head_pos = '0;
                        tail_pos = '0;
                        ring_copy[0] = val;
                    end
                    else if (kind == REQ_INS_FRONT)
                    begin
                        head_pos = step_down(head_pos);
                        ring_copy[head_pos] = val;
                    end
                    else
                    begin
                        tail_pos = step_up(tail_pos);
                        ring_copy[tail_pos] = val;
                    end
                    expect_result(ST_OK, VAL_ZERO, 1'b1);
                end
            end
            REQ_DEL_FRONT, REQ_DEL_REAR:
            begin
                if (deque_void)
                begin
                    expect_result(ST_EMPTY, VAL_ZERO, 1'b1);
                end
                else
                begin
                    taken = (kind == REQ_DEL_FRONT) ? ring_copy[head_pos] : ring_copy[tail_pos];
                    if (head_pos == tail_pos)
                    begin
                        clear_deque();
                    end
                    else if (kind == REQ_DEL_FRONT)
                    begin
                        head_pos = step_up(head_pos);
                    end
                    else
                    begin
                        tail_pos = step_down(tail_pos);
                    end
                    expect_result(ST_OK, taken, 1'b1);
                end
            end
            REQ_LIST:
            begin
                if (deque_void)
                begin
                    expect_result(ST_EMPTY, VAL_ZERO, 1'b1);
                end
                else
                begin
                    pos = head_pos;
                    k = 0;
                    at_end = 1'b0;
                    while (!at_end)
                    begin
                        at_end = (pos == tail_pos) || (k + 1 >= DEPTH);
                        expect_result(ST_OK, ring_copy[pos], at_end);
                        k++;
                        pos = step_up(pos);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_result(input status_t st, input data_t d, input logic lst);
        deque_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("%0t: unexpected result status=%0d data=%0d last=%0b",
                         $realtime, st, d, lst);
            end
        end
        else
        begin
            want = pending_results.pop_front();
            if (st !== want.status || d !== want.data || lst !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: result mismatch: expected status=%0d data=%0d last=%0b, got status=%0d data=%0d last=%0b",
                             $realtime, want.status, want.data, want.last, st, d, lst);
                end
            end
        end
    endtask

    // Offers one request after a random idle gap and waits for its acceptance.
    task automatic send_request(input req_type_t kind, input data_t val);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 50)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value <= val;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predict_request(kind, val);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic data_t pick_value();
        int roll;
        roll = $urandom_range(0, 15);
        case (roll)
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_ZERO;
            3: return VAL_NEG_ONE;
            default: return data_t'($urandom());
        endcase
    endfunction

    task automatic test_empty_deque();
        send_request(REQ_LIST, VAL_ZERO);
        send_request(REQ_DEL_FRONT, VAL_MAX);
        send_request(REQ_DEL_REAR, VAL_MIN);
        send_request(REQ_UNUSED_5, VAL_NEG_ONE);
        send_request(REQ_UNUSED_6, VAL_MAX);
        send_request(REQ_UNUSED_7, VAL_MIN);
        send_request(REQ_INS_REAR, 32'sd42);
        send_request(REQ_DEL_REAR, VAL_ZERO);
    endtask

    task automatic test_fill_and_drain();
        send_request(REQ_INS_FRONT, VAL_MIN);
        send_request(REQ_INS_REAR, VAL_MAX);
        send_request(REQ_INS_FRONT, VAL_ZERO);
        send_request(REQ_INS_REAR, VAL_NEG_ONE);
        send_request(REQ_INS_FRONT, 32'sh5555_5555);
        send_request(REQ_INS_REAR, 32'shAAAA_AAAA);
        send_request(REQ_INS_FRONT, 32'sd1);
        send_request(REQ_INS_REAR, 32'sh7FFF_FFFE);
        send_request(REQ_INS_FRONT, 32'sd2);
        send_request(REQ_INS_REAR, 32'sd3);
        send_request(REQ_LIST, VAL_ZERO);
        send_request(REQ_UNUSED_5, VAL_MAX);
        send_request(REQ_DEL_FRONT, VAL_ZERO);
        send_request(REQ_DEL_REAR, VAL_ZERO);
        send_request(REQ_LIST, VAL_ZERO);
        repeat (3)
        begin
            send_request(REQ_DEL_FRONT, VAL_ZERO);
        end
        repeat (3)
        begin
            send_request(REQ_DEL_REAR, VAL_ZERO);
        end
        send_request(REQ_LIST, VAL_ZERO);
    endtask

    // Bursts of sixteen requests lean towards filling, draining or neither,
    // so that the deque visits every fill level and wraps in both directions.
    task automatic test_random_traffic(input int op_count);
        int        done;
        int        roll;
        int        insert_pct;
        req_type_t kind;
        done = 0;
        insert_pct = 45;
        while (done < op_count)
        begin
            if (done % 16 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 75;
                    1: insert_pct = 20;
                    default: insert_pct = 45;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                kind = req_type_t'($urandom_range(5, 7));
            end
            else if (roll < 16)
            begin
                kind = REQ_LIST;
                done++;
            end
            else if ($urandom_range(0, 99) < insert_pct)
            begin
                kind = ($urandom_range(0, 1) != 0) ? REQ_INS_FRONT : REQ_INS_REAR;
                done++;
            end
            else
            begin
                kind = ($urandom_range(0, 1) != 0) ? REQ_DEL_FRONT : REQ_DEL_REAR;
                done++;
            end
            send_request(kind, pick_value());
        end
    endtask

    task automatic test_receiver_backlog();
        fork
            begin
                hold_rsp <= 1'b1;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_rsp <= 1'b0;
            end
        join_none
        repeat (6)
        begin
            send_request(REQ_INS_REAR, pick_value());
        end
        send_request(REQ_LIST, VAL_ZERO);
        repeat (5)
        begin
            send_request(REQ_DEL_FRONT, VAL_ZERO);
        end
        req_ch.valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_rsp = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cycle_count = 0;
        mismatch_count = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INS_FRONT;
        req_ch.value = VAL_ZERO;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_copy[i] = VAL_ZERO;
        end
        clear_deque();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(20, 78);
        test_empty_deque();
        test_fill_and_drain();
        test_random_traffic(70);
        set_idling(78, 20);
        test_random_traffic(70);
        set_idling(0, 0);
        test_receiver_backlog();
        test_random_traffic(70);

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_circular_deque_core passed");
        end
        else
        begin
            $display("tb_circular_deque_core failed");
        end
        $finish;
    end

endmodule
